// ----- rtl/macd_pkg.sv -----
`default_nettype none
package macd_pkg;
   localparam int HISTORY_DEPTH_DEF = 256;
   localparam int LEN_W = 8;
   localparam int UNIT_W = 16;
   localparam int PRICE_W = 32;
   localparam int SIG_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_FAST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNIT = 2'd3;
   // window sum: up to 256 prices of 32 bits
   localparam int SUM_W = PRICE_W + LEN_W + 1;
   localparam int TOT_W = SUM_W + LEN_W + 2;
endpackage
`default_nettype wire

// ----- rtl/macd_div.sv -----
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle
module macd_div
   import macd_pkg::*;
#(
   parameter int NUM_W = SUM_W,
   parameter int DEN_W = SUM_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo = q_ff;
endmodule
`default_nettype wire

// ----- rtl/macd_sign_signal.sv -----
// Per item, from accept to rsp_valid: for each of the fast positions the block reads
// slow+1 prices from history, then runs two divisions (mid and slow means); a final
// division sets the sign. Bad lengths or warm-up go straight to the output.
// Throughput: one item at a time; req_ready is low from accept until the result is taken.
// Reset: registers return to fast 3, mid 12, slow 26, unit 1; history count and
// write pointer clear; history RAM contents stay undefined.
`default_nettype none
module macd_sign_signal
   import macd_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PRICE_W-1:0]    req_price,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [SIG_W-1:0]    rsp_signal,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [UNIT_W-1:0]     csr_write_data
);
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int TW = $clog2(HISTORY_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0, S_POS = 3'd1, S_RD = 3'd2, S_ACC = 3'd3,
                          S_DIV = 3'd4, S_FIN = 3'd5, S_FDIV = 3'd6, S_OUT = 3'd7;

   logic [LEN_W-1:0]  fast_ff, mid_ff, slow_ff;
   logic [UNIT_W-1:0] unit_ff;
   logic [PRICE_W-1:0] mem [HISTORY_DEPTH];
   logic [PRICE_W-1:0] rd_ff;
   logic [AW-1:0] wp_ff;
   logic [TW-1:0] ticks_ff;
   logic [2:0] st_ff;
   logic [LEN_W-1:0] pos_ff;
   logic [LEN_W:0] off_ff;
   logic [SUM_W-1:0] sum_mid_ff, sum_slow_ff, mean_mid_ff;
   logic phase_ff;
   logic signed [TOT_W-1:0] tot_ff;
   logic rd_pend_ff, cur_mid_ff;
   logic ok_ff;
   logic signed [SIG_W-1:0] sig_ff;
   logic out_ff;

   logic div_start, div_done;
   logic [SUM_W-1:0] div_num, div_den, div_quo;
   logic [AW-1:0] rd_addr;
   logic [TW+LEN_W:0] age_ext;
   logic cur_ok_mid, cur_ok_slow;
   logic [SUM_W-1:0] tot_abs;

   macd_div #(.NUM_W(SUM_W), .DEN_W(SUM_W)) u_div (
      .clock, .reset, .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quo(div_quo));

   assign req_ready = (st_ff == S_IDLE) && !out_ff;
   assign rsp_valid = out_ff;
   assign rsp_signal = sig_ff;

   // age pos+off; newest at wp-1
   assign age_ext = (TW+LEN_W+1)'(pos_ff) + (TW+LEN_W+1)'(off_ff);
   assign rd_addr = wp_ff - AW'(1) - AW'(age_ext);
   assign cur_ok_mid = (ticks_ff != '0) &&
      ((TW+LEN_W+1)'(ticks_ff) - 1 >= (TW+LEN_W+1)'(pos_ff) + (TW+LEN_W+1)'(mid_ff));
   assign cur_ok_slow = (ticks_ff != '0) &&
      ((TW+LEN_W+1)'(ticks_ff) - 1 >= (TW+LEN_W+1)'(pos_ff) + (TW+LEN_W+1)'(slow_ff));
   assign tot_abs = tot_ff[TOT_W-1] ? SUM_W'(-tot_ff) : SUM_W'(tot_ff);

   always_comb begin
      div_start = 1'b0; div_num = sum_mid_ff; div_den = SUM_W'(mid_ff) + 1'b1;
      if (st_ff == S_ACC && !rd_pend_ff && off_ff > (LEN_W+1)'(slow_ff)) begin
         div_start = 1'b1;
      end
      if (phase_ff) begin
         div_num = sum_slow_ff; div_den = SUM_W'(slow_ff) + 1'b1;
      end
      if (st_ff == S_FIN) begin
         div_start = 1'b1; div_num = tot_abs; div_den = SUM_W'({fast_ff, 8'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) mem[wp_ff] <= req_price;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= 8'd3; mid_ff <= 8'd12; slow_ff <= 8'd26; unit_ff <= 16'd1;
         wp_ff <= '0; ticks_ff <= '0; st_ff <= S_IDLE; out_ff <= 1'b0;
         phase_ff <= 1'b0; rd_pend_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_FAST: fast_ff <= csr_write_data[LEN_W-1:0];
               REG_MID:  mid_ff <= csr_write_data[LEN_W-1:0];
               REG_SLOW: slow_ff <= csr_write_data[LEN_W-1:0];
               REG_UNIT: unit_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) out_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req_valid && req_ready) begin
               wp_ff <= wp_ff + 1'b1;
               if (ticks_ff != TW'(HISTORY_DEPTH)) ticks_ff <= ticks_ff + 1'b1;
               ok_ff <= (fast_ff >= 8'd1) && (fast_ff < mid_ff) && (mid_ff < slow_ff) &&
                  (unit_ff != '0) &&
                  ((TW+1)'(ticks_ff != TW'(HISTORY_DEPTH)) + (TW+1)'(ticks_ff)
                     >= (TW+1)'(slow_ff)) &&
                  (32'(fast_ff) + 32'(slow_ff) <= 32'(HISTORY_DEPTH));
               pos_ff <= '0; tot_ff <= '0;
               st_ff <= S_POS;
            end
            S_POS: begin
               if (!ok_ff) begin
                  sig_ff <= '0; st_ff <= S_OUT;
               end else if (pos_ff == fast_ff) begin
                  st_ff <= S_FIN;
               end else begin
                  off_ff <= '0; sum_mid_ff <= '0; sum_slow_ff <= '0;
                  phase_ff <= 1'b0; rd_pend_ff <= 1'b0;
                  st_ff <= S_RD;
               end
            end
            S_RD: begin
               // issue read at off
               rd_pend_ff <= 1'b1; cur_mid_ff <= off_ff <= (LEN_W+1)'(mid_ff);
               off_ff <= off_ff + 1'b1;
               st_ff <= S_ACC;
            end
            S_ACC: begin
               if (rd_pend_ff) begin
                  rd_pend_ff <= 1'b0;
                  sum_slow_ff <= sum_slow_ff + SUM_W'(rd_ff);
                  if (cur_mid_ff) sum_mid_ff <= sum_mid_ff + SUM_W'(rd_ff);
                  if (off_ff <= (LEN_W+1)'(slow_ff)) st_ff <= S_RD;
               end else begin
                  st_ff <= S_DIV;
               end
            end
            S_DIV: if (div_done) begin
               if (!phase_ff) begin
                  mean_mid_ff <= cur_ok_mid ? div_quo : '0;
                  phase_ff <= 1'b1;
                  st_ff <= S_ACC;
                  rd_pend_ff <= 1'b0;
               end else begin
                  tot_ff <= tot_ff + TOT_W'(mean_mid_ff)
                            - TOT_W'(cur_ok_slow ? div_quo : '0);
                  pos_ff <= pos_ff + 1'b1;
                  st_ff <= S_POS;
               end
            end
            S_FIN: st_ff <= S_FDIV;
            S_FDIV: if (div_done) begin
               if (div_quo == '0) sig_ff <= '0;
               else if (tot_ff[TOT_W-1]) sig_ff <= -SIG_W'(unit_ff);
               else sig_ff <= SIG_W'(unit_ff);
               st_ff <= S_OUT;
            end
            S_OUT: begin
               out_ff <= 1'b1; st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
